/* rtl/core/gcse_pkg.sv */
// Shared types, opcode constants and result codes for the command stream executor.
`timescale 1ns / 1ps

package gcse_pkg;

    // Default queue depths
    localparam int unsigned CMD_QUEUE_DEPTH_DEF = 4;
    localparam int unsigned OUT_QUEUE_DEPTH_DEF = 2;

    // Command register indexes
    localparam logic [7:0] OP_BIN_XY      = 8'd0;
    localparam logic [7:0] OP_WAIT        = 8'd1;
    localparam logic [7:0] OP_INTERRUPT   = 8'd2;
    localparam logic [7:0] OP_DMA_SETUP0  = 8'd3;
    localparam logic [7:0] OP_DMA_SETUP1  = 8'd4;
    localparam logic [7:0] OP_DMA_LOCAL0  = 8'd5;
    localparam logic [7:0] OP_DMA_LOCAL1  = 8'd6;
    localparam logic [7:0] OP_DMA_BUS0    = 8'd7;
    localparam logic [7:0] OP_DMA_BUS1    = 8'd8;
    localparam logic [7:0] OP_VEC_XY      = 8'd9;
    localparam logic [7:0] OP_VEC_ZW      = 8'd10;
    localparam logic [7:0] OP_EXEC_DMA0   = 8'd11;
    localparam logic [7:0] OP_EXEC_DMA1   = 8'd12;
    localparam logic [7:0] OP_EXEC_GLOBAL = 8'd13;
    localparam logic [7:0] OP_EXEC_SHARED = 8'd14;
    localparam logic [7:0] OP_EXEC_LAUNCH = 8'd15;

    // Status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_WAIT    = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    // Work item kinds
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_DMA    = 3'd1;
    localparam logic [2:0] KIND_GLOBAL = 3'd2;
    localparam logic [2:0] KIND_SHARED = 3'd3;
    localparam logic [2:0] KIND_LAUNCH = 3'd4;

    localparam logic [3:0]  LAUNCH_PC_MASK  = 4'hf;
    localparam logic [10:0] LAUNCH_COUNT_ONE = 11'd1;

    // Command class assigned by the front end
    typedef enum logic [3:0] {
        CLS_TICK,
        CLS_SKIP,
        CLS_NOP,
        CLS_BIN,
        CLS_WAIT,
        CLS_DMA_SETUP,
        CLS_DMA_LOCAL,
        CLS_DMA_BUS,
        CLS_VEC_XY,
        CLS_VEC_ZW,
        CLS_EXEC_DMA,
        CLS_EXEC_GLOBAL,
        CLS_EXEC_SHARED,
        CLS_EXEC_LAUNCH,
        CLS_UNKNOWN
    } cmd_class_t;

    typedef struct packed {
        cmd_class_t  cls;
        logic        unit;
        logic [31:0] value;
        logic [31:0] busy;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        waiting;
        logic [2:0]  work_kind;
        logic        unit_index;
        logic [31:0] dma_setup;
        logic [31:0] dma_local_addr;
        logic [31:0] dma_bus_addr;
        logic [31:0] attr_index;
        logic [63:0] attr_value;
        logic [3:0]  launch_pc;
        logic [10:0] launch_count;
        logic [31:0] bin_xy;
    } result_t;

endpackage

/* rtl/core/gcse_fifo.sv */
// Small register FIFO used for the command queue and the result queue.
`timescale 1ns / 1ps

module gcse_fifo
    import gcse_pkg::*;
#(
    parameter type         ITEM_T = cmd_t,
    parameter int unsigned DEPTH  = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  ITEM_T wr_item,
    output logic  full,
    input  logic  pop,
    output ITEM_T rd_item,
    output logic  empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ITEM_T            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

/* rtl/core/gcse_front.sv */
// Front end: accepts words and classifies them into decoded commands.
`timescale 1ns / 1ps

module gcse_front
    import gcse_pkg::*;
(
    input  logic        push,
    output logic        full,
    input  logic        func,
    input  logic        skip_write,
    input  logic [7:0]  cmd_index,
    input  logic [31:0] value,
    input  logic [31:0] unit_busy,
    output logic        q_push,
    input  logic        q_full,
    output cmd_t        q_cmd
);

    cmd_class_t cls;

    assign full   = q_full;
    assign q_push = push;

    always_comb
    begin
        cls = CLS_UNKNOWN;
        if (func)
        begin
            cls = CLS_TICK;
        end
        else if (skip_write)
        begin
            cls = CLS_SKIP;
        end
        else
        begin
            unique case (cmd_index)
                OP_BIN_XY:                    cls = CLS_BIN;
                OP_WAIT:                      cls = CLS_WAIT;
                OP_INTERRUPT:                 cls = CLS_NOP;
                OP_DMA_SETUP0, OP_DMA_SETUP1: cls = CLS_DMA_SETUP;
                OP_DMA_LOCAL0, OP_DMA_LOCAL1: cls = CLS_DMA_LOCAL;
                OP_DMA_BUS0, OP_DMA_BUS1:     cls = CLS_DMA_BUS;
                OP_VEC_XY:                    cls = CLS_VEC_XY;
                OP_VEC_ZW:                    cls = CLS_VEC_ZW;
                OP_EXEC_DMA0, OP_EXEC_DMA1:   cls = CLS_EXEC_DMA;
                OP_EXEC_GLOBAL:               cls = CLS_EXEC_GLOBAL;
                OP_EXEC_SHARED:               cls = CLS_EXEC_SHARED;
                OP_EXEC_LAUNCH:               cls = CLS_EXEC_LAUNCH;
                default:                      cls = CLS_UNKNOWN;
            endcase
        end
    end

    // Unit 0 sits on the odd index of every per-unit pair
    always_comb
    begin
        q_cmd.cls   = cls;
        q_cmd.unit  = ~cmd_index[0];
        q_cmd.value = value;
        q_cmd.busy  = unit_busy;
    end

endmodule

/* rtl/core/gcse_back.sv */
// Back end: holds executor state, carries out commands and queues results.
`timescale 1ns / 1ps

module gcse_back
    import gcse_pkg::*;
#(
    parameter int unsigned OUT_QUEUE_DEPTH = OUT_QUEUE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    input  logic    res_pop,
    output result_t res,
    output logic    res_empty
);

    logic        wait_reg, wait_next;
    logic [31:0] mask_reg, mask_next;
    logic [31:0] setup_reg [2];
    logic [31:0] local_reg [2];
    logic [31:0] bus_reg [2];
    logic [31:0] vec_xy_reg, vec_xy_next;
    logic [31:0] vec_zw_reg, vec_zw_next;
    logic [15:0] bin_x_reg, bin_x_next;
    logic [15:0] bin_y_reg, bin_y_next;
    logic        out_full;
    logic        step;
    result_t     r;

    assign step    = cmd_valid && !out_full;
    assign cmd_pop = step;

    always_comb
    begin
        wait_next   = wait_reg;
        mask_next   = mask_reg;
        vec_xy_next = vec_xy_reg;
        vec_zw_next = vec_zw_reg;
        bin_x_next  = bin_x_reg;
        bin_y_next  = bin_y_reg;
        r           = '0;
        r.status    = ST_DONE;
        priority if (cmd.cls == CLS_TICK)
        begin
            if (wait_reg && ((cmd.busy & mask_reg) == '0))
            begin
                wait_next = 1'b0;
            end
        end
        else if (wait_reg)
        begin
            r.status = ST_REJECT;
        end
        else
        begin
            unique case (cmd.cls)
                CLS_BIN:
                begin
                    bin_x_next = cmd.value[15:0];
                    bin_y_next = cmd.value[31:16];
                end
                CLS_WAIT:
                begin
                    mask_next = cmd.value;
                    if ((cmd.busy & cmd.value) != '0)
                    begin
                        wait_next = 1'b1;
                        r.status  = ST_WAIT;
                    end
                end
                CLS_VEC_XY: vec_xy_next = cmd.value;
                CLS_VEC_ZW: vec_zw_next = cmd.value;
                CLS_EXEC_DMA:
                begin
                    r.work_kind      = KIND_DMA;
                    r.unit_index     = cmd.unit;
                    r.dma_setup      = setup_reg[cmd.unit];
                    r.dma_local_addr = local_reg[cmd.unit];
                    r.dma_bus_addr   = bus_reg[cmd.unit];
                end
                CLS_EXEC_GLOBAL, CLS_EXEC_SHARED:
                begin
                    r.work_kind  = (cmd.cls == CLS_EXEC_GLOBAL) ? KIND_GLOBAL : KIND_SHARED;
                    r.attr_index = cmd.value;
                    r.attr_value = {vec_zw_reg, vec_xy_reg};
                end
                CLS_EXEC_LAUNCH:
                begin
                    r.work_kind    = KIND_LAUNCH;
                    r.launch_pc    = cmd.value[3:0] & LAUNCH_PC_MASK;
                    r.launch_count = {1'b0, cmd.value[13:4]} + LAUNCH_COUNT_ONE;
                end
                CLS_UNKNOWN: r.status = ST_UNKNOWN;
                // DMA register writes are done in the clocked block; skip,
                // interrupt and tick need nothing here
                default: ;
            endcase
        end
        r.waiting = wait_next;
        r.bin_xy  = {bin_y_next, bin_x_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg   <= 1'b0;
            mask_reg   <= '0;
            vec_xy_reg <= '0;
            vec_zw_reg <= '0;
            bin_x_reg  <= '0;
            bin_y_reg  <= '0;
            for (int i = 0; i < 2; i++)
            begin
                setup_reg[i] <= '0;
                local_reg[i] <= '0;
                bus_reg[i]   <= '0;
            end
        end
        else if (step)
        begin
            wait_reg   <= wait_next;
            mask_reg   <= mask_next;
            vec_xy_reg <= vec_xy_next;
            vec_zw_reg <= vec_zw_next;
            bin_x_reg  <= bin_x_next;
            bin_y_reg  <= bin_y_next;
            if (!wait_reg)
            begin
                if (cmd.cls == CLS_DMA_SETUP)
                begin
                    setup_reg[cmd.unit] <= cmd.value;
                end
                if (cmd.cls == CLS_DMA_LOCAL)
                begin
                    local_reg[cmd.unit] <= cmd.value;
                end
                if (cmd.cls == CLS_DMA_BUS)
                begin
                    bus_reg[cmd.unit] <= cmd.value;
                end
            end
        end
    end

    gcse_fifo #(
        .ITEM_T (result_t),
        .DEPTH  (OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (step),
        .wr_item (r),
        .full    (out_full),
        .pop     (res_pop),
        .rd_item (res),
        .empty   (res_empty)
    );

endmodule

/* rtl/core/gpu_command_stream_executor_core.sv */
// Top level of the GPU command stream executor.
`timescale 1ns / 1ps
//
// Usage:
//   Input side is a queue write port: drive func, skip_write, cmd_index,
//   value and unit_busy with push high; the word is taken at a rising edge
//   where full is low. Every word, packet or status tick, yields exactly one
//   result word.
//   Result side is a queue read port: while empty is low the oldest result
//   sits on status .. bin_xy; pop at a rising edge takes it.
//   Path: a taken word is decoded and written into the command queue at
//   that edge; the execute stage then takes it from there and writes its
//   result into the result queue, after which the result is visible.
//   Throughput: one word per cycle unless the result queue is full;
//   it executes one command per cycle on a single set of state registers.
//   Stall: if pop is held low the result queue fills, execution holds, the
//   command queue then fills and full rises; nothing is dropped.
//   A WAIT stalls command execution logically (commands are answered with
//   the rejected status) until a tick clears the masked busy bits; the
//   handshake itself keeps moving.
//   Reset: all executor state clears to zero, both queues empty, full low.
//
module gpu_command_stream_executor_core
    import gcse_pkg::*;
#(
    parameter int unsigned CMD_QUEUE_DEPTH = CMD_QUEUE_DEPTH_DEF,
    parameter int unsigned OUT_QUEUE_DEPTH = OUT_QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        func,
    input  logic        skip_write,
    input  logic [7:0]  cmd_index,
    input  logic [31:0] value,
    input  logic [31:0] unit_busy,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic        waiting,
    output logic [2:0]  work_kind,
    output logic        unit_index,
    output logic [31:0] dma_setup,
    output logic [31:0] dma_local_addr,
    output logic [31:0] dma_bus_addr,
    output logic [31:0] attr_index,
    output logic [63:0] attr_value,
    output logic [3:0]  launch_pc,
    output logic [10:0] launch_count,
    output logic [31:0] bin_xy
);

    logic    q_push, q_full, q_empty, q_pop;
    cmd_t    q_wr_cmd, q_rd_cmd;
    result_t res;

    // Decode incoming words
    gcse_front u_front (
        .push       (push),
        .full       (full),
        .func       (func),
        .skip_write (skip_write),
        .cmd_index  (cmd_index),
        .value      (value),
        .unit_busy  (unit_busy),
        .q_push     (q_push),
        .q_full     (q_full),
        .q_cmd      (q_wr_cmd)
    );

    // Decouple decode from execution
    gcse_fifo #(
        .ITEM_T (cmd_t),
        .DEPTH  (CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (q_wr_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .rd_item (q_rd_cmd),
        .empty   (q_empty)
    );

    // Execute against state and queue results
    gcse_back #(
        .OUT_QUEUE_DEPTH (OUT_QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (q_rd_cmd),
        .cmd_pop   (q_pop),
        .res_pop   (pop),
        .res       (res),
        .res_empty (empty)
    );

    assign status         = res.status;
    assign waiting        = res.waiting;
    assign work_kind      = res.work_kind;
    assign unit_index     = res.unit_index;
    assign dma_setup      = res.dma_setup;
    assign dma_local_addr = res.dma_local_addr;
    assign dma_bus_addr   = res.dma_bus_addr;
    assign attr_index     = res.attr_index;
    assign attr_value     = res.attr_value;
    assign launch_pc      = res.launch_pc;
    assign launch_count   = res.launch_count;
    assign bin_xy         = res.bin_xy;

endmodule

/* rtl/core/gcse_checker.sv */
// Port-level checker for the command stream executor and its bind.
`timescale 1ns / 1ps

module gcse_checker
    import gcse_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  status,
    input logic        waiting,
    input logic [2:0]  work_kind,
    input logic [10:0] launch_count
);

    // Result queue comes out of reset empty
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty in reset");

    // Entering or being rejected by a wait always reports the stalled flag
    a_wait_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == ST_WAIT || status == ST_REJECT)) |-> waiting)
        else $error("wait or reject status without waiting flag");

    // Work items only come from commands executed while running
    a_work_running: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && work_kind != KIND_NONE) |-> (status == ST_DONE && !waiting))
        else $error("work item emitted while stalled or with bad status");

    // A held result word keeps its status
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(work_kind)))
        else $error("stalled result word changed");

    // Launches always carry at least one instance
    a_launch_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && work_kind == KIND_LAUNCH) |-> (launch_count != '0))
        else $error("launch with zero count");

endmodule

bind gpu_command_stream_executor_core gcse_checker u_gcse_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .status       (status),
    .waiting      (waiting),
    .work_kind    (work_kind),
    .launch_count (launch_count)
);
